>>> hdl/swts_pkg.sv
// Shared constants, codes and types for the sorted word table search block.
// Used by every module in hdl/ but swts_ram, and by the testbench; depends on nothing.
package swts_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int PROBE_W     = 13;

    // word geometry: three 64-bit parts, bytes past WORD_BYTES are zeroed
    localparam int WORD_BYTES = 24;
    localparam int PART_W     = 64;
    localparam int WORD_W     = 3 * PART_W;

    // first-letter index
    localparam logic [7:0] LETTER_A = 8'h61;
    localparam int         LETTERS  = 26;
    localparam int         LETTER_W = $clog2(LETTERS);

    // search mode codes
    localparam logic [1:0] MODE_SEQ    = 2'd0;
    localparam logic [1:0] MODE_BIN    = 2'd1;
    localparam logic [1:0] MODE_LETTER = 2'd2;
    localparam logic [1:0] MODE_RESET  = MODE_BIN;

    // action codes
    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    // result of one word-to-entry compare
    typedef struct packed {
        logic lt;   // query word below entry
        logic eq;   // query word equals entry
    } cmp_result_t;

    // keep mask for one 64-bit part of a word
    function automatic logic [PART_W-1:0] part_mask(input int part);
        int kept;
        kept = WORD_BYTES - 8 * part;
        if (kept >= 8)
            return '1;
        else if (kept <= 0)
            return '0;
        else
            return {PART_W{1'b1}} << (8 * (8 - kept));
    endfunction

endpackage

>>> hdl/swts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module swts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/swts_cmp.sv
// Shared compare unit: orders the query word against one table entry.
// Depends on swts_pkg for word widths and the compare result type.
module swts_cmp (
    input  logic [swts_pkg::WORD_W-1:0] word,
    input  logic [swts_pkg::WORD_W-1:0] entry,
    output swts_pkg::cmp_result_t       result
);

    // big-endian packing makes string order plain unsigned order
    always_comb
    begin
        result.lt = word < entry;
        result.eq = word == entry;
    end

endmodule

>>> hdl/swts_letters.sv
// Per-letter word counters with one increment port and one read port.
// Depends on swts_pkg for count and letter widths.
module swts_letters (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          inc,
    input  logic [swts_pkg::LETTER_W-1:0] inc_idx,
    input  logic [swts_pkg::LETTER_W-1:0] rd_idx,
    output logic [swts_pkg::COUNT_W-1:0]  rd_count
);

    logic [swts_pkg::COUNT_W-1:0] count_reg [swts_pkg::LETTERS];

    // count appended words per first letter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < swts_pkg::LETTERS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (inc)
        begin
            count_reg[inc_idx] <= count_reg[inc_idx] + 1'b1;
        end
    end

    // read the selected counter
    assign rd_count = count_reg[rd_idx];

endmodule

>>> hdl/sorted_word_table_search.sv
// Top level of the sorted word table search: sequencer, table RAM, compare unit.
// Depends on swts_pkg, swts_ram, swts_cmp and swts_letters.
// Append: busy stays low. Query: each table compare is a CHECK (RAM read), then a
// COMPARE; a miss that empties the range closes in CHECK. done pulses as busy falls.
// Mode 2 first sums the counts of earlier letters in PREFIX. Binary search over
// 4096 entries: at most 13 compares; sequential: up to one compare per entry.
// Mode 3 or a non-letter word in mode 2: done on the next cycle.
// The receiver cannot stall. Reset clears entry and letter counts, search_mode binary.
module sorted_word_table_search (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          action,
    input  logic [63:0]                   word_high,
    input  logic [63:0]                   word_mid,
    input  logic [63:0]                   word_low,
    output logic                          done,
    output logic                          found,
    output logic [12:0]                   probes,
    input  logic                          search_mode_wr,
    input  logic [1:0]                    search_mode_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREFIX,
        ST_CHECK,
        ST_COMPARE
    } state_t;

    localparam logic [63:0] MASK_HIGH = swts_pkg::part_mask(0);
    localparam logic [63:0] MASK_MID  = swts_pkg::part_mask(1);
    localparam logic [63:0] MASK_LOW  = swts_pkg::part_mask(2);

    state_t                           state_reg;
    logic [1:0]                       mode_reg;
    logic [swts_pkg::COUNT_W-1:0]     count_reg;
    logic [swts_pkg::WORD_W-1:0]      word_reg;
    logic [swts_pkg::COUNT_W-1:0]     lo_reg;
    logic [swts_pkg::COUNT_W-1:0]     hi_reg;
    logic [swts_pkg::LETTER_W-1:0]    letter_reg;
    logic [swts_pkg::LETTER_W-1:0]    scan_reg;
    logic                             seq_reg;
    logic [swts_pkg::PROBE_W-1:0]     probes_reg;
    logic                             found_reg;
    logic                             done_reg;

    logic [swts_pkg::WORD_W-1:0]      word_in;
    logic [7:0]                       first_byte;
    logic                             is_letter;
    logic [swts_pkg::LETTER_W-1:0]    letter_idx;
    logic                             accept;
    logic                             append_ok;
    logic [swts_pkg::COUNT_W:0]       mid_sum;
    logic [swts_pkg::COUNT_W-1:0]     mid_c;
    logic [swts_pkg::COUNT_W-1:0]     probe_idx;
    logic [swts_pkg::COUNT_W-1:0]     mid_reg;
    logic [swts_pkg::WORD_W-1:0]      entry;
    logic [swts_pkg::COUNT_W-1:0]     letter_count;
    swts_pkg::cmp_result_t            cmp;

    // mask and decode the incoming word
    assign word_in    = {word_high & MASK_HIGH, word_mid & MASK_MID, word_low & MASK_LOW};
    assign first_byte = word_in[swts_pkg::WORD_W-1 -: 8];
    assign is_letter  = (first_byte >= swts_pkg::LETTER_A) &&
                        (first_byte < swts_pkg::LETTER_A + 8'(swts_pkg::LETTERS));
    assign letter_idx = swts_pkg::LETTER_W'(first_byte - swts_pkg::LETTER_A);

    assign accept    = start && (state_reg == ST_IDLE);
    assign append_ok = accept && (action == swts_pkg::ACT_APPEND) &&
                       (count_reg < swts_pkg::COUNT_W'(swts_pkg::TABLE_DEPTH));

    // midpoint of the open range [lo, hi)
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg} - 1'b1;
    assign mid_c     = mid_sum[swts_pkg::COUNT_W:1];
    assign probe_idx = seq_reg ? lo_reg : mid_c;

    swts_ram #(
        .WIDTH (swts_pkg::WORD_W),
        .DEPTH (swts_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (append_ok),
        .waddr (count_reg[swts_pkg::ADDR_W-1:0]),
        .wdata (word_in),
        .raddr (probe_idx[swts_pkg::ADDR_W-1:0]),
        .rdata (entry)
    );

    swts_cmp u_cmp (
        .word   (word_reg),
        .entry  (entry),
        .result (cmp)
    );

    swts_letters u_letters (
        .clk      (clk),
        .rst_n    (rst_n),
        .inc      (append_ok && is_letter),
        .inc_idx  (letter_idx),
        .rd_idx   (scan_reg),
        .rd_count (letter_count)
    );

    // sequencer with registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mode_reg   <= swts_pkg::MODE_RESET;
            count_reg  <= '0;
            word_reg   <= '0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
            probes_reg <= '0;
            seq_reg    <= 1'b0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            mid_reg    <= '0;
            scan_reg   <= '0;
            letter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (search_mode_wr)
            begin
                mode_reg <= search_mode_data;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        word_reg   <= word_in;
                        probes_reg <= '0;
                        found_reg  <= 1'b0;
                        letter_reg <= letter_idx;
                        scan_reg   <= '0;
                        lo_reg     <= '0;
                        hi_reg     <= count_reg;
                        if (action == swts_pkg::ACT_APPEND)
                        begin
                            if (append_ok)
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            case (mode_reg)
                                swts_pkg::MODE_SEQ:
                                begin
                                    seq_reg   <= 1'b1;
                                    state_reg <= ST_CHECK;
                                end
                                swts_pkg::MODE_BIN:
                                begin
                                    seq_reg   <= 1'b0;
                                    state_reg <= ST_CHECK;
                                end
                                swts_pkg::MODE_LETTER:
                                begin
                                    seq_reg <= 1'b0;
                                    if (is_letter)
                                    begin
                                        state_reg <= ST_PREFIX;
                                    end
                                    else
                                    begin
                                        done_reg <= 1'b1;
                                    end
                                end
                                default:
                                begin
                                    done_reg <= 1'b1;
                                end
                            endcase
                        end
                    end
                end
                ST_PREFIX:
                begin
                    // sum counts of earlier letters, then close the range
                    if (scan_reg == letter_reg)
                    begin
                        hi_reg    <= lo_reg + letter_count;
                        state_reg <= ST_CHECK;
                    end
                    else
                    begin
                        lo_reg   <= lo_reg + letter_count;
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                ST_CHECK:
                begin
                    // issue a table read, or finish on an empty range
                    if (lo_reg < hi_reg)
                    begin
                        mid_reg    <= mid_c;
                        probes_reg <= probes_reg + 1'b1;
                        state_reg  <= ST_COMPARE;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_COMPARE:
                begin
                    // narrow the range from the compare outcome
                    if (cmp.eq)
                    begin
                        found_reg <= 1'b1;
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else if (seq_reg)
                    begin
                        if (cmp.lt)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            lo_reg    <= lo_reg + 1'b1;
                            state_reg <= ST_CHECK;
                        end
                    end
                    else
                    begin
                        if (cmp.lt)
                        begin
                            hi_reg <= mid_reg;
                        end
                        else
                        begin
                            lo_reg <= mid_reg + 1'b1;
                        end
                        state_reg <= ST_CHECK;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // drive result and status ports
    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign found  = found_reg;
    assign probes = probes_reg;

endmodule

>>> verif/tb_sorted_word_table_search.sv
// Testbench for sorted_word_table_search: appends ascending words, queries them in all
// search modes and checks every done pulse against its own table search model.
// Depends on swts_pkg and the RTL under hdl/.
module tb_sorted_word_table_search;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         HALF_PERIOD = 5;
    // limit allows for a run in which every query is a full sequential scan
    localparam int         CYCLE_LIMIT = 20_000_000;
    localparam int         SETTLE      = 4;
    localparam int         TAIL_WAIT   = 64;
    localparam int         REPORT_MAX  = 10;
    localparam logic [1:0] MODE_NONE   = 2'd3;   // spare code: no search made

    typedef logic [swts_pkg::WORD_W-1:0] word_t;

    typedef struct packed {
        logic                         found;
        logic [swts_pkg::PROBE_W-1:0] probes;
    } lookup_t;

    localparam logic [7:0] LETTER_Z = 8'(swts_pkg::LETTER_A + swts_pkg::LETTERS - 1);
    localparam word_t      WORD_A   = {swts_pkg::LETTER_A, {(swts_pkg::WORD_W - 8){1'b0}}};
    localparam word_t      WORD_B   = {swts_pkg::LETTER_A + 8'd1,
                                       {(swts_pkg::WORD_W - 8){1'b0}}};

    logic        clk              = 1'b0;
    logic        rst_n            = 1'b0;
    logic        start            = 1'b0;
    logic        action           = swts_pkg::ACT_APPEND;
    logic [63:0] word_high        = '0;
    logic [63:0] word_mid         = '0;
    logic [63:0] word_low         = '0;
    logic        search_mode_wr   = 1'b0;
    logic [1:0]  search_mode_data = swts_pkg::MODE_RESET;
    logic        busy;
    logic        done;
    logic        found;
    logic [12:0] probes;

    // table mirror and search configuration
    word_t       stored_words [swts_pkg::TABLE_DEPTH];
    int unsigned stored_count = 0;
    int unsigned letter_tally [swts_pkg::LETTERS];
    logic [1:0]  active_mode  = swts_pkg::MODE_RESET;
    lookup_t     expected_lookups [$];

    int unsigned error_count  = 0;
    int unsigned burst_left   = 0;
    logic [7:0]  ladder_first = swts_pkg::LETTER_A;
    logic [7:0]  ladder_slot  = 8'h00;

    sorted_word_table_search u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .action           (action),
        .word_high        (word_high),
        .word_mid         (word_mid),
        .word_low         (word_low),
        .done             (done),
        .found            (found),
        .probes           (probes),
        .search_mode_wr   (search_mode_wr),
        .search_mode_data (search_mode_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic bit is_letter(input logic [7:0] b);
        return (b >= swts_pkg::LETTER_A) && (b <= LETTER_Z);
    endfunction

    // store one word unless the table is full; count its first letter
    function automatic void record_append(input word_t w);
        if (stored_count < swts_pkg::TABLE_DEPTH)
        begin
            stored_words[stored_count] = w;
            stored_count++;
            if (is_letter(w[swts_pkg::WORD_W-1 -: 8]))
                letter_tally[w[swts_pkg::WORD_W-1 -: 8] - swts_pkg::LETTER_A]++;
        end
    endfunction

    // search the mirrored table the way the active mode does
    function automatic lookup_t predict_lookup(input word_t w);
        lookup_t     r;
        int          lo;
        int          hi;
        int          mid;
        int unsigned count;
        bit          hit;
        logic [7:0]  first;
        hit   = 1'b0;
        count = 0;
        lo    = 0;
        hi    = -1;
        first = w[swts_pkg::WORD_W-1 -: 8];
        case (active_mode)
            swts_pkg::MODE_SEQ:
            begin
                for (int i = 0; i < int'(stored_count); i++)
                begin
                    count++;
                    if (w == stored_words[i])
                    begin
                        hit = 1'b1;
                        break;
                    end
                    if (w < stored_words[i])
                        break;
                end
            end
            swts_pkg::MODE_BIN:
            begin
                hi = int'(stored_count) - 1;
            end
            swts_pkg::MODE_LETTER:
            begin
                if (is_letter(first))
                begin
                    for (int k = 0; k < int'(first - swts_pkg::LETTER_A); k++)
                        lo += int'(letter_tally[k]);
                    hi = lo + int'(letter_tally[first - swts_pkg::LETTER_A]) - 1;
                end
            end
            default: ;
        endcase
        // halve [lo, hi]; the range is empty for sequential and spare modes and for non-letters in mode 2
        while (lo <= hi && !hit)
        begin
            mid = lo + (hi - lo) / 2;
            count++;
            if (w < stored_words[mid])
                hi = mid - 1;
            else if (w > stored_words[mid])
                lo = mid + 1;
            else
                hit = 1'b1;
        end
        r.found  = hit;
        r.probes = count[swts_pkg::PROBE_W-1:0];
        return r;
    endfunction

    function automatic word_t rand_word();
        return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    // first byte and second byte fixed, random tail, sometimes zero padded
    function automatic word_t ladder_word(input logic [7:0] first, input logic [7:0] slot);
        word_t w;
        int    keep;
        w = rand_word();
        w[swts_pkg::WORD_W-1 -: 16] = {first, slot};
        if ($urandom_range(0, 1) == 1)
        begin
            keep = $urandom_range(2, swts_pkg::WORD_BYTES - 1);
            w = w & ({swts_pkg::WORD_W{1'b1}} << (8 * (swts_pkg::WORD_BYTES - keep)));
        end
        return w;
    endfunction

    // next word of the ascending load sequence; climb first byte up to ceiling
    function automatic word_t next_sorted_word(input int unsigned advance_odds,
                                               input logic [7:0] ceiling);
        int step_to;
        if (ladder_first < ceiling &&
            (ladder_slot == 8'hff || $urandom_range(1, advance_odds) == 1))
        begin
            step_to      = int'(ladder_first) + $urandom_range(1, 2);
            ladder_first = (step_to > int'(ceiling)) ? ceiling : step_to[7:0];
            ladder_slot  = 8'h00;
        end
        if (ladder_slot != 8'hff)
            ladder_slot++;
        return ladder_word(ladder_first, ladder_slot);
    endfunction

    // mostly stored words, then near misses, letter words and raw noise
    function automatic word_t pick_query();
        int unsigned roll;
        word_t       w;
        roll = $urandom_range(0, 99);
        if (stored_count != 0 && roll < 50)
        begin
            w = stored_words[$urandom_range(0, stored_count - 1)];
        end
        else if (stored_count != 0 && roll < 70)
        begin
            w = stored_words[$urandom_range(0, stored_count - 1)];
            w = ($urandom_range(0, 1) == 1) ? w + 1'b1 : w - 1'b1;
        end
        else if (roll < 85)
        begin
            w = ladder_word(8'(swts_pkg::LETTER_A + $urandom_range(0, swts_pkg::LETTERS - 1)),
                            8'($urandom_range(0, 255)));
        end
        else
        begin
            w = rand_word();
        end
        return w;
    endfunction

    task automatic note_failure(input string what);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("%0t ns: %s", $realtime, what);
    endtask

    // send one word in bursts with random gaps; record or predict once busy is low again
    task automatic send_word(input logic act, input word_t w);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        start  <= 1'b1;
        action <= act;
        {word_high, word_mid, word_low} <= w;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        if (act == swts_pkg::ACT_APPEND)
            record_append(w);
        else
            expected_lookups.push_back(predict_lookup(w));
    endtask

    // hold start low until every pending query has answered and appends settled
    task automatic wait_idle();
        start <= 1'b0;
        burst_left = 0;
        while (expected_lookups.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_search_mode(input logic [1:0] mode);
        wait_idle();
        search_mode_wr   <= 1'b1;
        search_mode_data <= mode;
        @(posedge clk);
        active_mode = mode;
        search_mode_wr <= 1'b0;
    endtask

    // every mode on an empty table: no compares, nothing found
    task automatic test_empty_table();
        send_word(swts_pkg::ACT_QUERY, '1);
        set_search_mode(swts_pkg::MODE_SEQ);
        send_word(swts_pkg::ACT_QUERY, '0);
        set_search_mode(swts_pkg::MODE_LETTER);
        send_word(swts_pkg::ACT_QUERY, WORD_A);
        set_search_mode(MODE_NONE);
        send_word(swts_pkg::ACT_QUERY, rand_word());
    endtask

    // one-letter word in the table; hits, misses on both sides, non-letters
    task automatic test_single_entry();
        word_t below_a;
        word_t above_z;
        below_a = rand_word();
        below_a[swts_pkg::WORD_W-1 -: 8] = swts_pkg::LETTER_A - 8'd1;
        above_z = rand_word();
        above_z[swts_pkg::WORD_W-1 -: 8] = LETTER_Z + 8'd1;
        set_search_mode(swts_pkg::MODE_BIN);
        send_word(swts_pkg::ACT_APPEND, WORD_A);
        send_word(swts_pkg::ACT_QUERY, WORD_A);
        send_word(swts_pkg::ACT_QUERY, '0);
        send_word(swts_pkg::ACT_QUERY, '1);
        send_word(swts_pkg::ACT_QUERY, WORD_B);
        set_search_mode(swts_pkg::MODE_LETTER);
        send_word(swts_pkg::ACT_QUERY, WORD_A);
        send_word(swts_pkg::ACT_QUERY, below_a);
        send_word(swts_pkg::ACT_QUERY, above_z);
        set_search_mode(swts_pkg::MODE_SEQ);
        send_word(swts_pkg::ACT_QUERY, WORD_A);
        send_word(swts_pkg::ACT_QUERY, '1);
        send_word(swts_pkg::ACT_QUERY, '0);
        set_search_mode(MODE_NONE);
        send_word(swts_pkg::ACT_QUERY, WORD_A);
    endtask

    // grow the table through the alphabet while querying in rotating modes
    task automatic test_sorted_build();
        logic [1:0] next_mode;
        int         items;
        for (int round = 0; round < 12; round++)
        begin
            if (round == 6)
                next_mode = MODE_NONE;
            else if (round % 3 == 0)
                next_mode = swts_pkg::MODE_SEQ;
            else if (round % 3 == 1)
                next_mode = swts_pkg::MODE_BIN;
            else
                next_mode = swts_pkg::MODE_LETTER;
            set_search_mode(next_mode);
            items = (round == 6) ? 30 : 118;
            repeat (items)
            begin
                if ($urandom_range(0, 99) < 35)
                    send_word(swts_pkg::ACT_APPEND, next_sorted_word(28, LETTER_Z));
                else
                    send_word(swts_pkg::ACT_QUERY, pick_query());
            end
        end
    endtask

    // all modes against the loaded table; sequential kept short, it is slow
    task automatic test_loaded_table_queries();
        set_search_mode(swts_pkg::MODE_BIN);
        send_word(swts_pkg::ACT_QUERY, '1);
        send_word(swts_pkg::ACT_QUERY, '0);
        repeat (20) send_word(swts_pkg::ACT_QUERY, pick_query());
        set_search_mode(swts_pkg::MODE_LETTER);
        send_word(swts_pkg::ACT_QUERY, WORD_A);
        repeat (24) send_word(swts_pkg::ACT_QUERY, pick_query());
        set_search_mode(swts_pkg::MODE_SEQ);
        send_word(swts_pkg::ACT_QUERY, '1);
        send_word(swts_pkg::ACT_QUERY, '0);
        repeat (4)
            send_word(swts_pkg::ACT_QUERY, stored_words[$urandom_range(0, stored_count - 1)]);
        send_word(swts_pkg::ACT_QUERY, pick_query());
        set_search_mode(MODE_NONE);
        send_word(swts_pkg::ACT_QUERY, '1);
    endtask

    // compare each done pulse with the oldest pending query
    always @(posedge clk)
    begin
        lookup_t want;
        if (done === 1'b1)
        begin
            if (expected_lookups.size() == 0)
            begin
                note_failure($sformatf("result found=%0b probes=%0d with no query pending",
                                       found, probes));
            end
            else
            begin
                want = expected_lookups.pop_front();
                if (found !== want.found)
                    note_failure($sformatf("found mismatch: expected %0b, got %0b",
                                           want.found, found));
                if (probes !== want.probes)
                    note_failure($sformatf("probes mismatch: expected %0d, got %0d",
                                           want.probes, probes));
            end
        end
    end

    // end the run if the block hangs
    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_sorted_word_table_search: done, errors");
        $finish;
    end

    initial
    begin
        for (int k = 0; k < swts_pkg::LETTERS; k++)
            letter_tally[k] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_single_entry();
        test_sorted_build();
        test_loaded_table_queries();

        // drain, then watch for stray results
        wait_idle();
        repeat (TAIL_WAIT) @(posedge clk);
        if (expected_lookups.size() != 0)
            note_failure($sformatf("%0d queries never answered", expected_lookups.size()));
        if (error_count == 0)
            $display("tb_sorted_word_table_search: done, clean");
        else
            $display("tb_sorted_word_table_search: done, errors");
        $finish;
    end

endmodule

>>> sim.f
hdl/swts_pkg.sv
hdl/swts_ram.sv
hdl/swts_cmp.sv
hdl/swts_letters.sv
hdl/sorted_word_table_search.sv
verif/tb_sorted_word_table_search.sv
